/* src/mplm_pkg.sv */
// ============================================================================
// mplm_pkg
// Shared constants and types for the multiband pixel lookup-table mapper.
// ============================================================================
package mplm_pkg;

    // Default sizing of the table store
    localparam int DEF_MAX_ENTRIES = 65536;
    localparam int DEF_MAX_BANDS   = 4;
    localparam int DEF_WORD_BITS   = 64;

    // Fixed field widths of the channels
    localparam int PIXEL_W     = 32;
    localparam int WR_BAND_W   = 2;
    localparam int WR_ENTRY_W  = 16;
    localparam int DATA_W      = 64;
    localparam int OUT_BAND_W  = 2;
    localparam int TOTAL_W     = 32;

    // Configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int SIZE_W      = 17;
    localparam int BANDS_W     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_LUT_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LUT_BANDS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_BANDS = 2'd2;

    localparam logic [SIZE_W-1:0]  RST_LUT_SIZE    = 17'd256;
    localparam logic [BANDS_W-1:0] RST_LUT_BANDS   = 3'd1;
    localparam logic [BANDS_W-1:0] RST_IMAGE_BANDS = 3'd1;

    // Input command codes
    localparam logic CMD_MAP   = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Sideband that travels with each table read
    typedef struct packed {
        logic [OUT_BAND_W-1:0] out_band;
        logic                  clamped;
        logic [TOTAL_W-1:0]    total;
        logic                  last;
    } t_mplm_side;

endpackage

/* src/mplm_in_if.sv */
// ============================================================================
// mplm_in_if
// Input channel: map and table-write items with valid/ready handshake.
// ============================================================================
interface mplm_in_if;
    logic                               valid;
    logic                               ready;
    logic                               cmd;
    logic [mplm_pkg::PIXEL_W-1:0]       pixel_index;
    logic [mplm_pkg::WR_BAND_W-1:0]     write_band;
    logic [mplm_pkg::WR_ENTRY_W-1:0]    write_entry;
    logic [mplm_pkg::DATA_W-1:0]        write_real;
    logic [mplm_pkg::DATA_W-1:0]        write_imag;

    modport source (
        output valid, cmd, pixel_index, write_band, write_entry, write_real, write_imag,
        input  ready
    );
    modport sink (
        input  valid, cmd, pixel_index, write_band, write_entry, write_real, write_imag,
        output ready
    );
endinterface

/* src/mplm_out_if.sv */
// ============================================================================
// mplm_out_if
// Output channel: looked-up entries with band, clamp flag and total.
// ============================================================================
interface mplm_out_if;
    logic                               valid;
    logic                               ready;
    logic [mplm_pkg::DATA_W-1:0]        value_real;
    logic [mplm_pkg::DATA_W-1:0]        value_imag;
    logic [mplm_pkg::OUT_BAND_W-1:0]    out_band;
    logic                               clamped;
    logic [mplm_pkg::TOTAL_W-1:0]       overflow_total;
    logic                               last;

    modport source (
        output valid, value_real, value_imag, out_band, clamped, overflow_total, last,
        input  ready
    );
    modport sink (
        input  valid, value_real, value_imag, out_band, clamped, overflow_total, last,
        output ready
    );
endinterface

/* src/mplm_lut_mem.sv */
// ============================================================================
// mplm_lut_mem
// Table store: one write port, one registered read port with read enable.
// ============================================================================
module mplm_lut_mem #(
    parameter int MAX_ENTRIES = mplm_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_BANDS   = mplm_pkg::DEF_MAX_BANDS,
    parameter int WORD_BITS   = mplm_pkg::DEF_WORD_BITS,
    localparam int EW         = $clog2(MAX_ENTRIES),
    localparam int BW         = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [BW-1:0]        i_wr_band,
    input  logic [EW-1:0]        i_wr_entry,
    input  logic [WORD_BITS-1:0] i_wr_real,
    input  logic [WORD_BITS-1:0] i_wr_imag,
    input  logic                 i_rd_en,
    input  logic [BW-1:0]        i_rd_band,
    input  logic [EW-1:0]        i_rd_entry,
    output logic [WORD_BITS-1:0] o_rd_real,
    output logic [WORD_BITS-1:0] o_rd_imag
);

    localparam int DEPTH = MAX_BANDS * (2 ** EW);
    localparam int AW    = $clog2(DEPTH);

    logic [2*WORD_BITS-1:0] r_mem [DEPTH];
    logic [2*WORD_BITS-1:0] r_rd_word;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;

    // Band selects the block of entries; band is always below MAX_BANDS
    assign wr_addr = AW'({i_wr_band, i_wr_entry});
    assign rd_addr = AW'({i_rd_band, i_rd_entry});

    // Store one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[wr_addr] <= {i_wr_imag, i_wr_real};
        end
    end

    // Read one entry, hold while the read is not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_word <= r_mem[rd_addr];
        end
    end

    assign o_rd_real = r_rd_word[WORD_BITS-1:0];
    assign o_rd_imag = r_rd_word[2*WORD_BITS-1:WORD_BITS];

endmodule

/* src/multiband_pixel_lut_map.sv */
// ============================================================================
// multiband_pixel_lut_map
// Per-band lookup tables with index clamp, fan-out and rotating band select.
// ============================================================================
//
//  channel   dir  handshake          payload
//  i_in      in   valid/ready        cmd, pixel_index, write_band/entry/real/imag
//  o_out     out  valid/ready        value_real/imag, out_band, clamped, total, last
//  cfg       in   i_cfg_we (no wait) i_cfg_idx, i_cfg_data
//
//  Write items give no result. A map item in single-table or per-band mode
//  makes one table read; in fan-out mode it makes lut_bands reads through the
//  single table read port, and the next item waits until the issue stage is
//  empty or issues its last read. A result passes the issue stage and the
//  result stage before it is offered. Reset restores the config defaults,
//  clears band position, clamp count and pipe valids, and holds input ready
//  low; table contents are undefined until written. A stalled output holds
//  the result register and the issue stage, and input stalls behind them.
//
module multiband_pixel_lut_map #(
    parameter int MAX_ENTRIES = mplm_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_BANDS   = mplm_pkg::DEF_MAX_BANDS,
    parameter int WORD_BITS   = mplm_pkg::DEF_WORD_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mplm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mplm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    mplm_in_if.sink                           i_in,
    mplm_out_if.source                        o_out
);

    localparam int EW       = $clog2(MAX_ENTRIES);
    localparam int BW       = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int BAND_CAP = (MAX_BANDS < 7) ? MAX_BANDS : 7;
    localparam int SW       = mplm_pkg::SIZE_W;
    localparam int NW       = mplm_pkg::BANDS_W;

    // Configuration registers
    logic [SW-1:0] r_lut_size;
    logic [NW-1:0] r_lut_bands;
    logic [NW-1:0] r_image_bands;

    // Running state
    logic [1:0]                     r_band_pos;
    logic [mplm_pkg::TOTAL_W-1:0]   r_ovf_count;

    // Issue stage
    logic                           r_s1_valid;
    logic                           r_s1_fan;
    logic [NW-1:0]                  r_s1_z;
    logic [NW-1:0]                  r_s1_lb;
    logic [BW-1:0]                  r_s1_tbl;
    logic [EW-1:0]                  r_s1_entry;
    mplm_pkg::t_mplm_side           r_s1_side;

    // Result stage
    logic                           r_s2_valid;
    mplm_pkg::t_mplm_side           r_s2_side;
    logic [WORD_BITS-1:0]           rd_real;
    logic [WORD_BITS-1:0]           rd_imag;

    // Combinational
    logic [SW-1:0]                  size_eff;
    logic [SW-1:0]                  size_lim;
    logic [NW-1:0]                  lb_eff;
    logic [NW-1:0]                  ib_eff;
    logic [NW-1:0]                  div;
    logic [NW-1:0]                  pos;
    logic [NW-1:0]                  pos_inc;
    logic                           one_table;
    logic                           fan_mode;
    logic                           clamp;
    logic [EW-1:0]                  map_entry;
    logic [1:0]                     n_band_pos;
    logic [mplm_pkg::TOTAL_W-1:0]   n_ovf_count;
    logic                           in_accept;
    logic                           map_accept;
    logic                           wr_en;
    logic                           s2_open;
    logic                           s1_issue;
    logic                           s1_last;
    logic [NW-1:0]                  z_inc;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lut_size    <= mplm_pkg::RST_LUT_SIZE;
            r_lut_bands   <= mplm_pkg::RST_LUT_BANDS;
            r_image_bands <= mplm_pkg::RST_IMAGE_BANDS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mplm_pkg::CFG_LUT_SIZE:    r_lut_size    <= i_cfg_data[SW-1:0];
                mplm_pkg::CFG_LUT_BANDS:   r_lut_bands   <= i_cfg_data[NW-1:0];
                mplm_pkg::CFG_IMAGE_BANDS: r_image_bands <= i_cfg_data[NW-1:0];
                default: ;
            endcase
        end
    end

    // Bring config values into their legal ranges
    always_comb begin
        if (r_lut_size == '0) begin
            size_eff = SW'(1);
        end else if (r_lut_size > SW'(MAX_ENTRIES)) begin
            size_eff = SW'(MAX_ENTRIES);
        end else begin
            size_eff = r_lut_size;
        end
        size_lim = size_eff - SW'(1);

        if (r_lut_bands == '0) begin
            lb_eff = NW'(1);
        end else if (r_lut_bands > NW'(BAND_CAP)) begin
            lb_eff = NW'(BAND_CAP);
        end else begin
            lb_eff = r_lut_bands;
        end

        if (r_image_bands == '0) begin
            ib_eff = NW'(1);
        end else if (r_image_bands > NW'(BAND_CAP)) begin
            ib_eff = NW'(BAND_CAP);
        end else begin
            ib_eff = r_image_bands;
        end
    end

    assign one_table = (lb_eff == NW'(1));
    assign fan_mode  = !one_table && (ib_eff == NW'(1));

    // Rotating band position: position stays below 4, so one subtract wraps it
    always_comb begin
        div = one_table ? ib_eff : lb_eff;
        if (div == NW'(1)) begin
            pos = '0;
        end else if (NW'(r_band_pos) >= div) begin
            pos = NW'(r_band_pos) - div;
        end else begin
            pos = NW'(r_band_pos);
        end
        pos_inc    = (pos + NW'(1) == div) ? '0 : pos + NW'(1);
        n_band_pos = fan_mode ? r_band_pos : pos_inc[1:0];
    end

    // Index clamp and saturating clamp count
    assign clamp     = i_in.pixel_index > mplm_pkg::PIXEL_W'(size_lim);
    assign map_entry = clamp ? size_lim[EW-1:0] : i_in.pixel_index[EW-1:0];

    always_comb begin
        if (clamp && (r_ovf_count != '1)) begin
            n_ovf_count = r_ovf_count + mplm_pkg::TOTAL_W'(1);
        end else begin
            n_ovf_count = r_ovf_count;
        end
    end

    // Handshake and stage control
    assign s2_open    = !r_s2_valid || o_out.ready;
    assign s1_last    = !r_s1_fan || (r_s1_z == r_s1_lb - NW'(1));
    assign s1_issue   = r_s1_valid && s2_open;
    assign i_in.ready = i_rst_n && (!r_s1_valid || (s1_issue && s1_last));
    assign in_accept  = i_in.valid && i_in.ready;
    assign map_accept = in_accept && (i_in.cmd == mplm_pkg::CMD_MAP);
    assign wr_en      = in_accept && (i_in.cmd == mplm_pkg::CMD_WRITE)
                        && (32'(i_in.write_band) < 32'(MAX_BANDS))
                        && (32'(i_in.write_entry) < 32'(MAX_ENTRIES));
    assign z_inc      = r_s1_z + NW'(1);

    // On each map transfer the band position steps unless in fan-out, and the clamp count grows on a clamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_pos  <= '0;
            r_ovf_count <= '0;
        end else if (map_accept) begin
            r_band_pos  <= n_band_pos;
            r_ovf_count <= n_ovf_count;
        end
    end

    // Issue stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (map_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_issue && s1_last) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Issue stage payload: load a map item, or step to the next fan-out band
    always_ff @(posedge i_clk) begin
        if (map_accept) begin
            r_s1_fan          <= fan_mode;
            r_s1_z            <= '0;
            r_s1_lb           <= lb_eff;
            r_s1_entry        <= map_entry;
            r_s1_side.clamped <= clamp;
            r_s1_side.total   <= n_ovf_count;
            if (fan_mode) begin
                r_s1_tbl           <= '0;
                r_s1_side.out_band <= '0;
                r_s1_side.last     <= 1'b0;
            end else begin
                r_s1_tbl           <= one_table ? '0 : BW'(pos);
                r_s1_side.out_band <= pos[1:0];
                r_s1_side.last     <= 1'b1;
            end
        end else if (s1_issue && !s1_last) begin
            r_s1_z             <= z_inc;
            r_s1_tbl           <= BW'(z_inc);
            r_s1_side.out_band <= z_inc[1:0];
            r_s1_side.last     <= (z_inc == r_s1_lb - NW'(1));
        end
    end

    // Table store with registered read
    mplm_lut_mem #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_BANDS   (MAX_BANDS),
        .WORD_BITS   (WORD_BITS)
    ) u_mem (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_band  (BW'(i_in.write_band)),
        .i_wr_entry (EW'(i_in.write_entry)),
        .i_wr_real  (i_in.write_real[WORD_BITS-1:0]),
        .i_wr_imag  (i_in.write_imag[WORD_BITS-1:0]),
        .i_rd_en    (s1_issue),
        .i_rd_band  (r_s1_tbl),
        .i_rd_entry (r_s1_entry),
        .o_rd_real  (rd_real),
        .o_rd_imag  (rd_imag)
    );

    // Result stage: fill on issue, drain on output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_open) begin
            r_s2_valid <= s1_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_issue) begin
            r_s2_side <= r_s1_side;
        end
    end

    // Drive the output channel
    assign o_out.valid          = r_s2_valid;
    assign o_out.value_real     = mplm_pkg::DATA_W'(rd_real);
    assign o_out.value_imag     = mplm_pkg::DATA_W'(rd_imag);
    assign o_out.out_band       = r_s2_side.out_band;
    assign o_out.clamped        = r_s2_side.clamped;
    assign o_out.overflow_total = r_s2_side.total;
    assign o_out.last           = r_s2_side.last;

endmodule
